[hdl/address_range_to_prefix_blocks_defines.svh]
// Assertion macros used by the checker file of the range decomposer.
// Include guard keeps repeated includes harmless.
`ifndef ADDRESS_RANGE_TO_PREFIX_BLOCKS_DEFINES_SVH
`define ADDRESS_RANGE_TO_PREFIX_BLOCKS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpb assertion failed");

`endif

[hdl/arpb_pkg.sv]
`timescale 1ns / 1ps

package arpb_pkg;

    localparam int ADDR_W     = 32;
    localparam int SUM_W      = ADDR_W + 1;
    localparam int LEN_W      = 6;
    localparam int MAX_BLOCKS = 62;
    localparam int CNT_W      = 6;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_RANGE,
        ST_EMIT
    } arpb_state_t;

    // Operands of the shared adder: sum = a + b + cin.
    typedef struct packed
    {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic             cin;
    } alu_req_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] block_base;
        logic [LEN_W-1:0]  prefix_length;
        logic              last_block;
    } block_t;

    // Number of trailing zero bits; a zero address counts as fully aligned.
    function automatic logic [LEN_W-1:0] trailing_zeros(input logic [ADDR_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = LEN_W'(ADDR_W);
        for (int i = ADDR_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = LEN_W'(i);
            end
        end
        return n;
    endfunction

    // Position of the highest set bit of a nonzero count.
    function automatic logic [LEN_W-1:0] floor_log2(input logic [SUM_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (v[i])
            begin
                n = LEN_W'(i);
            end
        end
        return n;
    endfunction

endpackage

[hdl/arpb_in_if.sv]
`timescale 1ns / 1ps

interface arpb_in_if;
    import arpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] first_address;
    logic [ADDR_W-1:0] last_address;

    modport source (output valid, output first_address, output last_address, input ready);
    modport sink   (input valid, input first_address, input last_address, output ready);
endinterface

[hdl/arpb_out_if.sv]
`timescale 1ns / 1ps

interface arpb_out_if;
    import arpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_base;
    logic [LEN_W-1:0]  prefix_length;
    logic              last_block;

    modport source (output valid, output block_base, output prefix_length,
                    output last_block, input ready);
    modport sink   (input valid, input block_base, input prefix_length,
                    input last_block, output ready);
endinterface

[hdl/arpb_alu.sv]
`timescale 1ns / 1ps

module arpb_alu
(
    input  arpb_pkg::alu_req_t           req,
    output logic [arpb_pkg::SUM_W-1:0]   sum
);
    import arpb_pkg::*;

    // One carry-in adder serves the increment, the subtraction and the step.
    assign sum = req.a + req.b + SUM_W'(req.cin);

endmodule

[hdl/arpb_ctrl.sv]
`timescale 1ns / 1ps

module arpb_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [arpb_pkg::ADDR_W-1:0]  first_address,
    input  logic [arpb_pkg::ADDR_W-1:0]  last_address,
    output logic                         in_ready,
    output arpb_pkg::alu_req_t           alu_req,
    input  logic [arpb_pkg::SUM_W-1:0]   alu_sum,
    input  logic                         out_free,
    output logic                         emit,
    output arpb_pkg::block_t             block
);
    import arpb_pkg::*;

    arpb_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [SUM_W-1:0]  hi_reg, hi_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  tz_reg, tz_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [LEN_W-1:0]  fit;
    logic [LEN_W-1:0]  k;
    logic [SUM_W-1:0]  size;
    logic              done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        hi_reg  <= hi_next;
        rem_reg <= rem_next;
        tz_reg  <= tz_next;
    end

    // Block size is limited by the alignment of the current base and by what
    // is left of the range.
    always_comb
    begin
        fit  = floor_log2(rem_reg);
        k    = (fit < tz_reg) ? fit : tz_reg;
        size = SUM_W'(1) << k;
        done = (size >= rem_reg) || (count_reg == CNT_W'(MAX_BLOCKS - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        hi_next    = hi_reg;
        rem_next   = rem_reg;
        tz_next    = tz_reg;
        count_next = count_reg;
        emit       = 1'b0;
        in_ready   = (state_reg == ST_IDLE);
        alu_req    = '{a: {1'b0, cur_reg}, b: '0, cin: 1'b0};
        block      = '{block_base: cur_reg, prefix_length: LEN_W'(ADDR_W) - k,
                       last_block: done};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (last_address < first_address)
                    begin
                        cur_next = last_address;
                        hi_next  = {1'b0, first_address};
                    end
                    else
                    begin
                        cur_next = first_address;
                        hi_next  = {1'b0, last_address};
                    end
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Keep the exclusive upper end so the remaining count is one subtraction.
                alu_req    = '{a: hi_reg, b: '0, cin: 1'b1};
                hi_next    = alu_sum;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                alu_req    = '{a: hi_reg, b: ~{1'b0, cur_reg}, cin: 1'b1};
                rem_next   = alu_sum;
                tz_next    = trailing_zeros(cur_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                alu_req = '{a: {1'b0, cur_reg}, b: size, cin: 1'b0};
                if (out_free)
                begin
                    emit       = 1'b1;
                    cur_next   = alu_sum[ADDR_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    state_next = done ? ST_IDLE : ST_RANGE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/address_range_to_prefix_blocks.sv]
// The first block of a range passes through the load, range and emit states and
// then the output register. Each block takes two passes through the shared adder,
// and no new range is taken until the last block of the current one is emitted.
// The output register lets the next range be accepted while the final block waits.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and empties
// the output register; no range is held across reset.
`timescale 1ns / 1ps

module address_range_to_prefix_blocks
(
    input  logic        clk,
    input  logic        rst_n,
    arpb_in_if.sink     ranges,
    arpb_out_if.source  blocks
);
    import arpb_pkg::*;

    // The sequencer walks the range from its low end. For each block it first
    // forms the remaining address count and the alignment of the current base,
    // then picks the largest block that fits both and steps past it. The shared
    // adder handles all three arithmetic steps in turn.

    alu_req_t         alu_req;
    logic [SUM_W-1:0] alu_sum;
    logic             emit;
    block_t           block;
    logic             out_free;

    logic             out_valid_reg, out_valid_next;
    block_t           block_reg, block_next;

    arpb_alu u_alu
    (
        .req (alu_req),
        .sum (alu_sum)
    );

    arpb_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (ranges.valid),
        .first_address (ranges.first_address),
        .last_address  (ranges.last_address),
        .in_ready      (ranges.ready),
        .alu_req       (alu_req),
        .alu_sum       (alu_sum),
        .out_free      (out_free),
        .emit          (emit),
        .block         (block)
    );

    // The output register can take a new block when it is empty or when its
    // current transaction completes in this cycle.
    assign out_free = !out_valid_reg || blocks.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        block_next     = block_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            block_next     = block;
        end
        else if (blocks.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

    assign blocks.valid         = out_valid_reg;
    assign blocks.block_base    = block_reg.block_base;
    assign blocks.prefix_length = block_reg.prefix_length;
    assign blocks.last_block    = block_reg.last_block;

endmodule

[hdl/arpb_checker.sv]
`timescale 1ns / 1ps
`include "address_range_to_prefix_blocks_defines.svh"

module arpb_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [arpb_pkg::ADDR_W-1:0]  block_base,
    input  logic [arpb_pkg::LEN_W-1:0]   prefix_length
);
    import arpb_pkg::*;

    // A stalled block stays offered.
    `ARPB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // Prefix lengths never exceed the address width.
    `ARPB_ASSERT_NOW(a_len_range, clk, rst_n, out_valid, prefix_length <= LEN_W'(ADDR_W))

    // Every block base is aligned to the block size.
    `ARPB_ASSERT_NOW(a_aligned, clk, rst_n, out_valid,
        (ADDR_W'(block_base << prefix_length)) == '0)

    // A new range keeps the block busy in the following cycle.
    `ARPB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind address_range_to_prefix_blocks arpb_checker u_arpb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ranges.valid),
    .in_ready      (ranges.ready),
    .out_valid     (blocks.valid),
    .out_ready     (blocks.ready),
    .block_base    (blocks.block_base),
    .prefix_length (blocks.prefix_length)
);

[tb/address_range_to_prefix_blocks_test.sv]
`timescale 1ns / 1ps

// Testbench for the address range decomposer. Ranges are sent on the input
// channel, and an independent predictor splits each accepted range into the
// minimal list of aligned prefix blocks. Every block that the design shows
// on the output channel is checked, field by field, against the oldest
// predicted block. Both channels stall at random, except during one stretch
// where they run at full rate.
module address_range_to_prefix_blocks_test;
    import arpb_pkg::*;

    // The design emits no more than this many blocks for one range.
    localparam int BLOCK_LIMIT = 62;

    // Idle chance, in percent, for either side while random idling is enabled.
    localparam int IDLE_PERCENT = 38;

    logic clk;
    logic rst_n;

    arpb_in_if  ranges_if();
    arpb_out_if blocks_if();

    // Blocks that the predictor has produced and the design has not shown yet.
    block_t expected_blocks[$];

    int  mismatch_count;
    bit  idling_enabled;

    address_range_to_prefix_blocks DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ranges (ranges_if),
        .blocks (blocks_if)
    );

    // 100 MHz clock: five nanoseconds high, five low.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Every mismatch goes through here, so the final verdict only needs the count.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Number of trailing zero bits of an address. A zero address is taken as
    // aligned on every bit, which lets the range starting at zero grow to /0.
    function automatic int alignment_of(input logic [32:0] address);
        int bits;
        bits = 0;
        if (address[31:0] == 32'd0)
        begin
            return 32;
        end
        while (bits < 32 && address[bits] == 1'b0)
        begin
            bits++;
        end
        return bits;
    endfunction

    // Index of the highest set bit of a nonzero 33-bit count; the full space
    // holds 2^32 addresses, so the count needs the extra bit.
    function automatic int highest_bit_of(input logic [32:0] count);
        int bits;
        bits = 0;
        for (int i = 0; i < 33; i++)
        begin
            if (count[i])
            begin
                bits = i;
            end
        end
        return bits;
    endfunction

    // Splits one range into aligned prefix blocks in ascending order and
    // queues them. At each step the block is as large as both the alignment
    // of the current address and the number of addresses left allow.
    task automatic predict_blocks(input logic [31:0] end_a, input logic [31:0] end_b);
        logic [32:0] low_end;
        logic [32:0] high_end;
        logic [32:0] cursor;
        logic [32:0] remaining;
        logic [32:0] block_top;
        int          size_bits;
        int          produced;
        bit          done;
        block_t      block;

        low_end  = {1'b0, end_a};
        high_end = {1'b0, end_b};
        // A range given backwards is the same range.
        if (high_end < low_end)
        begin
            low_end  = {1'b0, end_b};
            high_end = {1'b0, end_a};
        end
        cursor   = low_end;
        produced = 0;
        done     = 1'b0;
        while (!done)
        begin
            remaining = high_end - cursor + 33'd1;
            size_bits = alignment_of(cursor);
            if (highest_bit_of(remaining) < size_bits)
            begin
                size_bits = highest_bit_of(remaining);
            end
            block_top = cursor + (33'd1 << size_bits) - 33'd1;
            // The block count guard also ends the list, even though a legal
            // 32-bit range never needs more than the limit.
            done = (block_top >= high_end) || (produced + 1 >= BLOCK_LIMIT);

            block.block_base    = cursor[31:0];
            block.prefix_length = LEN_W'(32 - size_bits);
            block.last_block    = done;
            expected_blocks     = {expected_blocks, block};
            produced++;
            cursor = block_top + 33'd1;
        end
    endtask

    // Sends one range. Inputs move only at falling edges. While idling is on,
    // valid may first drop while the random idle draws go on; otherwise it stays
    // high from the previous transaction, so back-to-back ranges get no gap at
    // all. The transaction is complete at the first rising edge where ready is
    // high, and only then is the range handed to the predictor.
    task automatic send_range(input logic [31:0] end_a, input logic [31:0] end_b);
        while (idling_enabled && $urandom_range(99) < IDLE_PERCENT)
        begin
            ranges_if.valid <= 1'b0;
            @(negedge clk);
        end
        ranges_if.valid         <= 1'b1;
        ranges_if.first_address <= end_a;
        ranges_if.last_address  <= end_b;
        @(posedge clk);
        while (!ranges_if.ready)
        begin
            @(posedge clk);
        end
        predict_blocks(end_a, end_b);
        @(negedge clk);
    endtask

    // Output back-pressure: ready is redrawn at every falling edge.
    always @(negedge clk)
    begin
        if (idling_enabled)
        begin
            blocks_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
        else
        begin
            blocks_if.ready <= 1'b1;
        end
    end

    // Result checker. A block is taken at a rising edge where valid and ready
    // are both high and is compared with the oldest predicted block.
    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && blocks_if.valid && blocks_if.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected block base=%h len=%0d last=%0b",
                                          blocks_if.block_base, blocks_if.prefix_length,
                                          blocks_if.last_block));
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (blocks_if.block_base !== want.block_base)
                begin
                    report_mismatch($sformatf("block_base got %h want %h",
                                              blocks_if.block_base, want.block_base));
                end
                if (blocks_if.prefix_length !== want.prefix_length)
                begin
                    report_mismatch($sformatf("prefix_length got %0d want %0d at base %h",
                                              blocks_if.prefix_length, want.prefix_length,
                                              want.block_base));
                end
                if (blocks_if.last_block !== want.last_block)
                begin
                    report_mismatch($sformatf("last_block got %0b want %0b at base %h",
                                              blocks_if.last_block, want.last_block,
                                              want.block_base));
                end
            end
        end
    end

    // Hand-picked ranges: single hosts at both ends of the space, the whole
    // space, backward ends, the range that needs the most blocks, and ranges
    // that end or start exactly on a large boundary.
    task automatic test_directed_ranges();
        send_range(32'h0000_0000, 32'h0000_0000);
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_range(32'h0A00_0001, 32'h0A00_0001);
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_range(32'hFFFF_FFFF, 32'h0000_0000);
        send_range(32'h0000_0001, 32'hFFFF_FFFE);
        send_range(32'hFFFF_FFFE, 32'h0000_0001);
        send_range(32'h0000_0001, 32'hFFFF_FFFF);
        send_range(32'h0000_0000, 32'hFFFF_FFFE);
        send_range(32'h8000_0000, 32'hFFFF_FFFF);
        send_range(32'h0000_0000, 32'h7FFF_FFFF);
        send_range(32'h7FFF_FFFF, 32'h8000_0000);
        send_range(32'h0000_0005, 32'h0000_0003);
        send_range(32'h0A00_0001, 32'h0A00_00FE);
        send_range(32'hC0A8_0100, 32'hC0A8_01FF);
        send_range(32'hAAAA_AAAA, 32'h5555_5555);
        send_range(32'h0000_0002, 32'h0000_0003);
        send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    endtask

    // Random ranges of several shapes, so that short runs, exact prefixes and
    // near-prefixes show up far more often than pure chance would give them.
    task automatic test_random_ranges(input int count);
        logic [31:0] low_end;
        logic [31:0] high_end;
        logic [31:0] host_mask;
        int          shape;
        int          prefix_bits;

        for (int i = 0; i < count; i++)
        begin
            shape = $urandom_range(3);
            case (shape)
                0:
                begin
                    // Two unrelated addresses: usually a long list of blocks.
                    low_end  = $urandom;
                    high_end = $urandom;
                end
                1:
                begin
                    // A short run of addresses; may wrap, which turns it backward.
                    low_end  = $urandom;
                    high_end = low_end + $urandom_range(0, 300);
                end
                2:
                begin
                    // Exactly one aligned prefix, from /0 to /32.
                    prefix_bits = $urandom_range(0, 32);
                    host_mask   = 32'((33'd1 << (32 - prefix_bits)) - 33'd1);
                    low_end     = $urandom & ~host_mask;
                    high_end    = low_end | host_mask;
                end
                default:
                begin
                    // Flipped low bits: ends that sit near a prefix boundary.
                    low_end  = $urandom;
                    high_end = low_end ^ (32'hFFFF_FFFF >> $urandom_range(0, 31));
                end
            endcase
            if ($urandom_range(1) == 1)
            begin
                send_range(high_end, low_end);
            end
            else
            begin
                send_range(low_end, high_end);
            end
        end
    endtask

    // Stimulus sequence. Reset is applied once; all inputs are known from the
    // first instant of the run.
    initial
    begin
        mismatch_count          = 0;
        idling_enabled          = 1'b1;
        rst_n                   = 1'b0;
        ranges_if.valid         = 1'b0;
        ranges_if.first_address = '0;
        ranges_if.last_address  = '0;
        blocks_if.ready         = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_ranges();
        test_random_ranges(110);

        // A stretch at full rate on both sides, to hit back-to-back transactions.
        idling_enabled = 1'b0;
        test_random_ranges(35);
        idling_enabled = 1'b1;
        test_random_ranges(20);
        ranges_if.valid <= 1'b0;

        // Drain, then keep waiting for any stray block to show up.
        while (expected_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog. A run that has not finished by this time limit is reported as failed.
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
